[src/nicff_pkg.sv]
// Shared types and constants of the NIC frame filter and receive queue.
package nicff_pkg;

    localparam int MAC_W      = 48;
    localparam int LEN_W      = 16;
    localparam int CMD_W      = 3;
    localparam int SEL_W      = 3;
    localparam int STS_W      = 3;
    localparam int PKT_CNT_W  = 32;
    localparam int BYTE_CNT_W = 48;

    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = CMD_W + SEL_W;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = STS_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_LINK_UP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LINK_DOWN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRANSMIT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECEIVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POLL      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_STAT = 3'd5;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STS_W-1:0] STS_LINK_DOWN  = 3'd1;
    localparam logic [STS_W-1:0] STS_TOO_LONG   = 3'd2;
    localparam logic [STS_W-1:0] STS_FILTERED   = 3'd3;
    localparam logic [STS_W-1:0] STS_QUEUE_FULL = 3'd4;
    localparam logic [STS_W-1:0] STS_EMPTY      = 3'd5;

    // Statistics selectors.
    localparam logic [SEL_W-1:0] SEL_TX_PKTS   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_TX_OCTETS = 3'd1;
    localparam logic [SEL_W-1:0] SEL_TX_ERRS   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_RX_PKTS   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_RX_OCTETS = 3'd4;
    localparam logic [SEL_W-1:0] SEL_RX_DROPS  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISC     = 2'd2;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd1500;
    localparam logic [MAC_W-1:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

    // Frame descriptor, destination in the lowest bits.
    typedef struct packed {
        logic [LEN_W-1:0] tag;
        logic [LEN_W-1:0] flen;
        logic [LEN_W-1:0] plen;
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dest;
    } t_desc;

    // One registered input beat.
    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [CMD_W-1:0] cmd;
        t_desc            desc;
    } t_in_beat;

endpackage

[src/nic_frame_filter_and_rx_queue.sv]
// NIC command block: address filter, receive descriptor queue and statistics.
// A command waits in the input register and its result in the result register,
// which drives the output; back-pressure holds both. Throughput: one command per
// cycle, limited only by back-pressure.
// Reset (i_rst_n low, synchronous) takes the link down, empties the queue,
// zeroes all counters and restores the configuration registers; no clearing pass.
module nic_frame_filter_and_rx_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nicff_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nicff_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Command stream in.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: dest_mac[47:0], src_mac[95:48], payload_len[111:96],
    //        frame_len[127:112], frame_tag[143:128]
    input  logic [nicff_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: command[2:0], stat_select[5:3]
    input  logic [nicff_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // Result stream out.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: out_dest_mac[47:0], out_src_mac[95:48], out_payload_len[111:96],
    //        out_frame_len[127:112], out_tag[143:128], stat_value[191:144],
    //        link_is_up[192], zero fill[199:193]
    output logic [nicff_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: status[2:0], frame_valid[3]
    output logic [nicff_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import nicff_pkg::*;

    // Queue pointers are wide enough to index the memory; the fill count must
    // also hold the full depth itself.
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    // Configuration registers.
    logic [MAC_W-1:0]      r_station;
    logic [LEN_W-1:0]      r_max_pay;
    logic                  r_promisc;

    // Input register.
    logic                  r_in_valid;
    t_in_beat              r_in;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    // Block state.
    logic                  r_link,      n_link;
    logic [AW-1:0]         r_head,      n_head;
    logic [AW-1:0]         r_tail,      n_tail;
    logic [CW-1:0]         r_count,     n_count;
    logic [PKT_CNT_W-1:0]  r_tx_pkts,   n_tx_pkts;
    logic [PKT_CNT_W-1:0]  r_tx_errs,   n_tx_errs;
    logic [PKT_CNT_W-1:0]  r_rx_pkts,   n_rx_pkts;
    logic [PKT_CNT_W-1:0]  r_rx_drops,  n_rx_drops;
    logic [BYTE_CNT_W-1:0] r_tx_octets, n_tx_octets;
    logic [BYTE_CNT_W-1:0] r_rx_octets, n_rx_octets;

    // Descriptor memory and its registered read port, which always holds
    // the entry at the current head.
    t_desc                 r_mem [QUEUE_DEPTH];
    t_desc                 r_rd_desc;

    logic                  w_adv;
    logic                  w_wr_en;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_accept;
    logic [STS_W-1:0]      w_status;
    logic                  w_frame_valid;
    t_desc                 w_out_desc;
    logic [MAC_W-1:0]      w_stat_val;

    // The command in the input register is executed when the result register
    // is free or is being emptied in this cycle.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Receive filter: promiscuous, broadcast or our own address.
    assign w_accept = r_promisc || (r_in.desc.dest == BCAST_MAC)
                      || (r_in.desc.dest == r_station);

    // Command execution. Everything here acts on the registered beat and the
    // current state; the results are only committed when w_adv is high.
    always_comb begin
        n_link        = r_link;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_tx_pkts     = r_tx_pkts;
        n_tx_errs     = r_tx_errs;
        n_rx_pkts     = r_rx_pkts;
        n_rx_drops    = r_rx_drops;
        n_tx_octets   = r_tx_octets;
        n_rx_octets   = r_rx_octets;
        w_status      = STS_OK;
        w_frame_valid = 1'b0;
        w_out_desc    = '0;
        w_stat_val    = '0;
        w_wr_en       = 1'b0;

        unique case (r_in.cmd)
            CMD_LINK_UP: begin
                n_link = 1'b1;
            end
            CMD_LINK_DOWN: begin
                // Dropping the link also flushes the receive queue.
                n_link  = 1'b0;
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            CMD_TRANSMIT: begin
                // Link is checked before the length.
                if (!r_link) begin
                    w_status  = STS_LINK_DOWN;
                    n_tx_errs = r_tx_errs + 1'b1;
                end else if (r_in.desc.plen > r_max_pay) begin
                    w_status  = STS_TOO_LONG;
                    n_tx_errs = r_tx_errs + 1'b1;
                end else begin
                    n_tx_pkts      = r_tx_pkts + 1'b1;
                    n_tx_octets    = r_tx_octets + BYTE_CNT_W'(r_in.desc.flen);
                    w_frame_valid  = 1'b1;
                    w_out_desc     = r_in.desc;
                    w_out_desc.src = r_station;
                end
            end
            CMD_RECEIVE: begin
                if (!r_link) begin
                    w_status = STS_LINK_DOWN;
                end else if (!w_accept) begin
                    w_status = STS_FILTERED;
                end else begin
                    // An accepted frame is counted even when it is dropped.
                    n_rx_pkts   = r_rx_pkts + 1'b1;
                    n_rx_octets = r_rx_octets + BYTE_CNT_W'(r_in.desc.flen);
                    if (r_count == DEPTH_CNT) begin
                        w_status   = STS_QUEUE_FULL;
                        n_rx_drops = r_rx_drops + 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            CMD_POLL: begin
                // Polling works whatever the link state.
                if (r_count == '0) begin
                    w_status = STS_EMPTY;
                end else begin
                    w_frame_valid = 1'b1;
                    w_out_desc    = r_rd_desc;
                    n_head        = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            CMD_READ_STAT: begin
                case (r_in.sel)
                    SEL_TX_PKTS:   w_stat_val = MAC_W'(r_tx_pkts);
                    SEL_TX_OCTETS: w_stat_val = r_tx_octets;
                    SEL_TX_ERRS:   w_stat_val = MAC_W'(r_tx_errs);
                    SEL_RX_PKTS:   w_stat_val = MAC_W'(r_rx_pkts);
                    SEL_RX_OCTETS: w_stat_val = r_rx_octets;
                    SEL_RX_DROPS:  w_stat_val = MAC_W'(r_rx_drops);
                    default:       w_stat_val = '0;
                endcase
            end
            default: begin
                // Undefined commands leave the state alone and report OK.
            end
        endcase
    end

    // The read port looks ahead at the head the next command will see.
    assign w_rd_addr = w_adv ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (w_adv && w_wr_en) begin
            r_mem[r_tail] <= r_in.desc;
        end
        // A descriptor written into an empty queue is forwarded to the read
        // register, so a poll right behind the receive sees it.
        if (w_adv && w_wr_en && (r_tail == w_rd_addr)) begin
            r_rd_desc <= r_in.desc;
        end else begin
            r_rd_desc <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station   <= '0;
            r_max_pay   <= MAX_PAYLOAD_RST;
            r_promisc   <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_link      <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_tx_pkts   <= '0;
            r_tx_errs   <= '0;
            r_rx_pkts   <= '0;
            r_rx_drops  <= '0;
            r_tx_octets <= '0;
            r_rx_octets <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STATION_MAC: r_station <= i_cfg_data[MAC_W-1:0];
                    CFG_MAX_PAYLOAD: r_max_pay <= i_cfg_data[LEN_W-1:0];
                    CFG_PROMISC:     r_promisc <= i_cfg_data[0];
                    default:         ;
                endcase
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_link      <= n_link;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_tx_pkts   <= n_tx_pkts;
                r_tx_errs   <= n_tx_errs;
                r_rx_pkts   <= n_rx_pkts;
                r_rx_drops  <= n_rx_drops;
                r_tx_octets <= n_tx_octets;
                r_rx_octets <= n_rx_octets;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.desc <= t_desc'(s_axis_tdata);
            r_in.cmd  <= s_axis_tuser[CMD_W-1:0];
            r_in.sel  <= s_axis_tuser[IN_USER_W-1:CMD_W];
        end
        if (w_adv) begin
            r_out_data <= {7'b0, n_link, w_stat_val, w_out_desc};
            r_out_user <= {w_frame_valid, w_status};
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("receive queue count exceeds depth");

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    // Link down leaves the link down and the queue empty.
    a_link_down_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.cmd == CMD_LINK_DOWN)) |=> (!r_link && (r_count == '0)))
        else $error("link down did not flush the queue");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the NIC frame filter, receive queue and statistics block.
`timescale 1ns / 1ps

module tb_top;
    import nicff_pkg::*;

    localparam int RXQ_DEPTH      = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int STAT_LSB       = IN_DATA_W;
    localparam int LINK_BIT       = STAT_LSB + BYTE_CNT_W;

    // The two command codes that the package leaves unnamed; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam logic [SEL_W-1:0] SEL_RSVD_6 = 3'd6;
    localparam logic [SEL_W-1:0] SEL_RSVD_7 = 3'd7;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic [STS_W-1:0]      status;
        logic                  frame_valid;
        t_desc                 frame;
        logic [BYTE_CNT_W-1:0] stat_value;
        logic                  link_up;
    } t_nic_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Predicted state of the block: configuration, link, receive queue and counters.
    logic [MAC_W-1:0]      cfg_station     = '0;
    logic [LEN_W-1:0]      cfg_max_payload = MAX_PAYLOAD_RST;
    logic                  cfg_promisc     = 1'b0;
    logic                  mdl_link_up     = 1'b0;
    t_desc                 rxq_store [RXQ_DEPTH];
    int                    rxq_head        = 0;
    int                    rxq_tail        = 0;
    int                    rxq_count       = 0;
    logic [PKT_CNT_W-1:0]  tx_pkts         = '0;
    logic [PKT_CNT_W-1:0]  tx_errs         = '0;
    logic [PKT_CNT_W-1:0]  rx_pkts         = '0;
    logic [PKT_CNT_W-1:0]  rx_drops        = '0;
    logic [BYTE_CNT_W-1:0] tx_octets       = '0;
    logic [BYTE_CNT_W-1:0] rx_octets       = '0;

    t_in_beat    pending_cmds[$];
    t_nic_result expected_results[$];
    t_in_beat    driven_cmd;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          tx_hold       = 1'b0;
    int          stall_cycles  = 0;
    int          error_count   = 0;
    int          results_seen  = 0;
    int          cfg_writes    = 0;
    int          cmd_seen [8];
    int          status_seen [8];

    nic_frame_filter_and_rx_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advances the predicted state by one command and returns the result it should give.
    task automatic predict_nic_result(input t_in_beat cmd_beat, output t_nic_result res);
        res = '0;
        case (cmd_beat.cmd)
            CMD_LINK_UP: begin
                mdl_link_up = 1'b1;
            end
            CMD_LINK_DOWN: begin
                // Dropping the link throws away every queued descriptor.
                mdl_link_up = 1'b0;
                rxq_head    = 0;
                rxq_tail    = 0;
                rxq_count   = 0;
            end
            CMD_TRANSMIT: begin
                // The link is checked before the length.
                if (!mdl_link_up) begin
                    res.status = STS_LINK_DOWN;
                    tx_errs    = tx_errs + 1'b1;
                end else if (cmd_beat.desc.plen > cfg_max_payload) begin
                    res.status = STS_TOO_LONG;
                    tx_errs    = tx_errs + 1'b1;
                end else begin
                    tx_pkts          = tx_pkts + 1'b1;
                    tx_octets        = tx_octets + BYTE_CNT_W'(cmd_beat.desc.flen);
                    res.frame_valid  = 1'b1;
                    res.frame        = cmd_beat.desc;
                    res.frame.src    = cfg_station;
                end
            end
            CMD_RECEIVE: begin
                if (!mdl_link_up) begin
                    res.status = STS_LINK_DOWN;
                end else if (!(cfg_promisc || cmd_beat.desc.dest == BCAST_MAC ||
                               cmd_beat.desc.dest == cfg_station)) begin
                    res.status = STS_FILTERED;
                end else begin
                    // A frame that passes the filter is counted even when it is dropped.
                    rx_pkts   = rx_pkts + 1'b1;
                    rx_octets = rx_octets + BYTE_CNT_W'(cmd_beat.desc.flen);
                    if (rxq_count >= RXQ_DEPTH) begin
                        rx_drops   = rx_drops + 1'b1;
                        res.status = STS_QUEUE_FULL;
                    end else begin
                        rxq_store[rxq_tail] = cmd_beat.desc;
                        rxq_tail            = (rxq_tail + 1) % RXQ_DEPTH;
                        rxq_count++;
                    end
                end
            end
            CMD_POLL: begin
                if (rxq_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.frame_valid = 1'b1;
                    res.frame       = rxq_store[rxq_head];
                    rxq_head        = (rxq_head + 1) % RXQ_DEPTH;
                    rxq_count--;
                end
            end
            CMD_READ_STAT: begin
                case (cmd_beat.sel)
                    SEL_TX_PKTS:   res.stat_value = BYTE_CNT_W'(tx_pkts);
                    SEL_TX_OCTETS: res.stat_value = tx_octets;
                    SEL_TX_ERRS:   res.stat_value = BYTE_CNT_W'(tx_errs);
                    SEL_RX_PKTS:   res.stat_value = BYTE_CNT_W'(rx_pkts);
                    SEL_RX_OCTETS: res.stat_value = rx_octets;
                    SEL_RX_DROPS:  res.stat_value = BYTE_CNT_W'(rx_drops);
                    default:       res.stat_value = '0;
                endcase
            end
            default: begin
            end
        endcase
        res.link_up = mdl_link_up;
    endtask

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    // Writes one register through the configuration channel and mirrors it in the prediction.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STATION_MAC: cfg_station     = value[MAC_W-1:0];
            CFG_MAX_PAYLOAD: cfg_max_payload = value[LEN_W-1:0];
            CFG_PROMISC:     cfg_promisc     = value[0];
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    // Waits until no beat is on the command bus and every predicted result has come back.
    // Pending commands count too unless the sender is held back.
    task automatic wait_until_idle();
        repeat (2) @(posedge i_clk);
        while ((!tx_hold && pending_cmds.size() != 0) || s_axis_tvalid ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic t_in_beat random_beat(input logic [CMD_W-1:0] cmd);
        t_in_beat b;
        b.cmd       = cmd;
        b.sel       = SEL_W'($urandom_range(0, 7));
        b.desc.dest = random_mac();
        b.desc.src  = random_mac();
        b.desc.plen = LEN_W'($urandom_range(0, 65535));
        b.desc.flen = LEN_W'($urandom_range(0, 65535));
        b.desc.tag  = LEN_W'($urandom_range(0, 65535));
        return b;
    endfunction

    // Transmit lengths cluster around the limit so both outcomes of the length check show up.
    function automatic logic [LEN_W-1:0] pick_payload_len();
        case ($urandom_range(0, 5))
            0:       return cfg_max_payload;
            1:       return cfg_max_payload + 1'b1;
            2:       return '0;
            3:       return '1;
            default: return LEN_W'($urandom_range(0, cfg_max_payload));
        endcase
    endfunction

    // Receive destinations: own address, broadcast, one-bit near misses and random ones.
    function automatic logic [MAC_W-1:0] pick_rx_dest();
        case ($urandom_range(0, 9))
            0, 1, 2: return cfg_station;
            3, 4:    return BCAST_MAC;
            5:       return cfg_station ^ (48'd1 << $urandom_range(0, MAC_W - 1));
            default: return random_mac();
        endcase
    endfunction

    function automatic t_in_beat random_cmd();
        t_in_beat b;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 7) begin
            b = random_beat(CMD_LINK_UP);
        end else if (roll < 10) begin
            b = random_beat(CMD_LINK_DOWN);
        end else if (roll < 30) begin
            b           = random_beat(CMD_TRANSMIT);
            b.desc.plen = pick_payload_len();
        end else if (roll < 62) begin
            b           = random_beat(CMD_RECEIVE);
            b.desc.dest = pick_rx_dest();
        end else if (roll < 84) begin
            b = random_beat(CMD_POLL);
        end else if (roll < 96) begin
            b = random_beat(CMD_READ_STAT);
        end else begin
            b = random_beat($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7);
        end
        return b;
    endfunction

    task automatic queue_random_cmds(input int count);
        t_in_beat b;
        int       queued;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 29) == 0) begin
                // Bring the link up, send a burst of receives that can overfill the receive queue, then poll it.
                pending_cmds.push_back(random_beat(CMD_LINK_UP));
                queued++;
                repeat ($urandom_range(14, 20)) begin
                    b           = random_beat(CMD_RECEIVE);
                    b.desc.dest = $urandom_range(0, 1) ? BCAST_MAC : cfg_station;
                    pending_cmds.push_back(b);
                    queued++;
                end
                repeat ($urandom_range(4, 20)) begin
                    pending_cmds.push_back(random_beat(CMD_POLL));
                    queued++;
                end
            end else begin
                pending_cmds.push_back(random_cmd());
                queued++;
            end
        end
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] dest,
                            input logic [MAC_W-1:0] src, input logic [LEN_W-1:0] plen,
                            input logic [LEN_W-1:0] flen, input logic [LEN_W-1:0] tag,
                            input logic [SEL_W-1:0] sel);
        t_in_beat b;
        b.cmd       = cmd;
        b.sel       = sel;
        b.desc.dest = dest;
        b.desc.src  = src;
        b.desc.plen = plen;
        b.desc.flen = flen;
        b.desc.tag  = tag;
        pending_cmds.push_back(b);
    endtask

    // Command driver: presents queued commands and predicts each one as it is taken.
    always @(posedge i_clk) begin : cmd_driver
        t_nic_result predicted;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_nic_result(driven_cmd, predicted);
                expected_results.push_back(predicted);
                cmd_seen[driven_cmd.cmd]++;
            end
            // A new beat may be offered only when the bus is free or its beat was just taken.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (!tx_hold && pending_cmds.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    driven_cmd = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= driven_cmd.desc;
                    s_axis_tuser  <= {driven_cmd.sel, driven_cmd.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_nic_result actual;
        t_nic_result wanted;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                actual.status      = m_axis_tuser[STS_W-1:0];
                actual.frame_valid = m_axis_tuser[STS_W];
                actual.frame       = m_axis_tdata[IN_DATA_W-1:0];
                actual.stat_value  = m_axis_tdata[STAT_LSB +: BYTE_CNT_W];
                actual.link_up     = m_axis_tdata[LINK_BIT];
                if (expected_results.size() == 0) begin
                    note_failure("result beat with no command outstanding");
                end else begin
                    wanted = expected_results.pop_front();
                    status_seen[wanted.status]++;
                    check_field("status", 64'(wanted.status), 64'(actual.status));
                    check_field("frame_valid", 64'(wanted.frame_valid), 64'(actual.frame_valid));
                    check_field("out_dest_mac", 64'(wanted.frame.dest), 64'(actual.frame.dest));
                    check_field("out_src_mac", 64'(wanted.frame.src), 64'(actual.frame.src));
                    check_field("out_payload_len", 64'(wanted.frame.plen),
                                64'(actual.frame.plen));
                    check_field("out_frame_len", 64'(wanted.frame.flen), 64'(actual.frame.flen));
                    check_field("out_tag", 64'(wanted.frame.tag), 64'(actual.frame.tag));
                    check_field("stat_value", 64'(wanted.stat_value), 64'(actual.stat_value));
                    check_field("link_is_up", 64'(wanted.link_up), 64'(actual.link_up));
                    check_field("zero fill", 64'd0,
                                64'(m_axis_tdata[OUT_DATA_W-1:LINK_BIT+1]));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (i_rst_n);
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int s;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands under the reset configuration (station 0, limit 1500, filtering on).
        send_idle_pct = 24;
        recv_idle_pct = 46;
        push_cmd(CMD_POLL, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_TRANSMIT, random_mac(), random_mac(), 16'd100, 16'd118, 16'h1234,
                 SEL_TX_PKTS);
        push_cmd(CMD_RECEIVE, BCAST_MAC, random_mac(), 16'd60, 16'd78, 16'h0001, SEL_TX_PKTS);
        push_cmd(CMD_RSVD_6, '1, '1, '1, '1, '1, SEL_RSVD_7);
        push_cmd(CMD_RSVD_7, '0, '0, '0, '0, '0, SEL_RSVD_6);
        push_cmd(CMD_LINK_UP, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_TRANSMIT, BCAST_MAC, '1, MAX_PAYLOAD_RST, '1, '1, SEL_TX_PKTS);
        push_cmd(CMD_TRANSMIT, random_mac(), '0, MAX_PAYLOAD_RST + 1'b1, 16'd1600, 16'h00AA,
                 SEL_TX_PKTS);
        push_cmd(CMD_TRANSMIT, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_RECEIVE, '0, '1, '1, '1, '1, SEL_TX_PKTS);
        push_cmd(CMD_RECEIVE, BCAST_MAC, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_RECEIVE, 48'h8000_0000_0000, random_mac(), 16'd64, 16'd82, 16'h0002,
                 SEL_TX_PKTS);
        push_cmd(CMD_POLL, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_RECEIVE, BCAST_MAC, random_mac(), 16'd40, 16'd58, 16'h0003, SEL_TX_PKTS);
        push_cmd(CMD_LINK_DOWN, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        push_cmd(CMD_POLL, '0, '0, '0, '0, '0, SEL_TX_PKTS);
        for (s = 0; s < 8; s++)
            push_cmd(CMD_READ_STAT, random_mac(), random_mac(), '0, '0, '0, SEL_W'(s));
        wait_until_idle();

        // First random phase: ordinary address, default length limit, filtering on.
        write_register(CFG_STATION_MAC, random_mac());
        write_register(CFG_MAX_PAYLOAD, CFG_DATA_W'(MAX_PAYLOAD_RST));
        write_register(CFG_PROMISC, '0);
        queue_random_cmds(210);
        // Partway through, hold the sender back until the block has answered
        // everything in flight, then let it go on with the rest.
        while (pending_cmds.size() > 100)
            @(posedge i_clk);
        tx_hold = 1'b1;
        wait_until_idle();
        tx_hold = 1'b0;
        queue_random_cmds(210);
        wait_until_idle();

        // Second phase: idling swapped, all-ones address, largest limit, promiscuous.
        send_idle_pct = 46;
        recv_idle_pct = 24;
        write_register(CFG_STATION_MAC, BCAST_MAC);
        write_register(CFG_MAX_PAYLOAD, 48'hFFFF);
        write_register(CFG_PROMISC, 48'd1);
        queue_random_cmds(420);
        wait_until_idle();

        // Third phase, no idling: zero address and zero limit, then a random setting.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_STATION_MAC, '0);
        write_register(CFG_MAX_PAYLOAD, '0);
        write_register(CFG_PROMISC, '0);
        queue_random_cmds(210);
        wait_until_idle();
        write_register(CFG_STATION_MAC, random_mac());
        write_register(CFG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(1, 9000)));
        write_register(CFG_PROMISC, 48'd1);
        queue_random_cmds(210);
        wait_until_idle();

        error_count += expected_results.size();
        $write("Checked %0d results: %0d transmit, %0d receive, %0d poll, ",
               results_seen, cmd_seen[CMD_TRANSMIT], cmd_seen[CMD_RECEIVE],
               cmd_seen[CMD_POLL]);
        $display("%0d stat reads, %0d link, %0d reserved; %0d register writes.",
                 cmd_seen[CMD_READ_STAT], cmd_seen[CMD_LINK_UP] + cmd_seen[CMD_LINK_DOWN],
                 cmd_seen[CMD_RSVD_6] + cmd_seen[CMD_RSVD_7], cfg_writes);
        $write("Outcomes: %0d ok, %0d link down, %0d too long, %0d filtered, ",
               status_seen[STS_OK], status_seen[STS_LINK_DOWN], status_seen[STS_TOO_LONG],
               status_seen[STS_FILTERED]);
        $display("%0d queue-full drops, %0d empty polls; %0d failures.",
                 status_seen[STS_QUEUE_FULL], status_seen[STS_EMPTY], error_count);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/nicff_pkg.sv
src/nic_frame_filter_and_rx_queue.sv
tb/tb_top.sv
